FILE: sv/bdtw_pkg.sv
// Shared constants, types and cost arithmetic for the banded DTW distance block.
package bdtw_pkg;

  localparam int MAX_LEN     = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int COST_W      = 48;
  localparam int BAND_W      = 11;
  localparam int ROW_W       = 16;
  localparam int CNT_W       = $clog2(MAX_LEN + 1);
  localparam int REF_AW      = $clog2(MAX_LEN);
  localparam int DIFF_W      = SAMPLE_BITS + 1;
  localparam int SQ_W        = 2 * SAMPLE_BITS;

  localparam logic [COST_W-1:0] COST_INF = {COST_W{1'b1}};
  localparam logic [ROW_W-1:0]  ROW_MAX  = {ROW_W{1'b1}};

  typedef enum logic {
    KIND_REF   = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef enum logic {
    REG_BAND   = 1'b0,
    REG_THRESH = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SPAN,
    ST_STREAM,
    ST_DRAIN,
    ST_ROW_DONE,
    ST_FIN_RD,
    ST_FIN
  } state_e;

  // one read slot of the row sweep; pre is the leading read of the diagonal
  typedef struct packed {
    logic             vld;
    logic             pre;
    logic [CNT_W-1:0] k;
  } issue_t;

  // which cost entries of the previous row are live; all others are infinity
  typedef struct packed {
    logic             prev_init;
    logic             prev_empty;
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
  } row_t;

  typedef struct packed {
    logic              we;
    logic [CNT_W-1:0]  addr;
    logic [COST_W-1:0] data;
  } cost_wr_t;

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                 input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a == COST_INF || b == COST_INF || s[COST_W]) begin
      return COST_INF;
    end
    return s[COST_W-1:0];
  endfunction

  function automatic logic [COST_W-1:0] min_cost(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // value of previous-row entry k given the raw memory word
  function automatic logic [COST_W-1:0] eff_cost(input logic [CNT_W-1:0]  k,
                                                  input logic [COST_W-1:0] data,
                                                  input row_t              prev);
    if (prev.prev_init) begin
      return (k == '0) ? '0 : COST_INF;
    end
    if (prev.prev_empty) begin
      return COST_INF;
    end
    if (k >= prev.lo && k <= prev.hi) begin
      return data;
    end
    return COST_INF;
  endfunction

endpackage

FILE: sv/bdtw_ref_store.sv
// Reference sample memory: one write port, one registered read port.
module bdtw_ref_store import bdtw_pkg::*; (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [REF_AW-1:0]             waddr_i,
  input  logic signed [SAMPLE_BITS-1:0] wdata_i,
  input  logic                          re_i,
  input  logic [REF_AW-1:0]             raddr_i,
  output logic signed [SAMPLE_BITS-1:0] rdata_o
);

  logic signed [SAMPLE_BITS-1:0] mem_q [MAX_LEN];
  logic signed [SAMPLE_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/bdtw_cost_store.sv
// Cost row memory: one write port, one registered read port that holds its data.
module bdtw_cost_store import bdtw_pkg::*; (
  input  logic              clk_i,
  input  cost_wr_t          wr_i,
  input  logic              re_i,
  input  logic [CNT_W-1:0]  raddr_i,
  output logic [COST_W-1:0] rdata_o
);

  logic [COST_W-1:0] mem_q [MAX_LEN + 1];
  logic [COST_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/bdtw_cell_pipe.sv
// Cell pipeline: read data in, squared difference and three-way minimum, write back.
module bdtw_cell_pipe import bdtw_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  issue_t                        iss_i,
  input  row_t                          row_i,
  input  logic signed [SAMPLE_BITS-1:0] q_i,
  input  logic [COST_W-1:0]             cost_rdata_i,
  input  logic signed [SAMPLE_BITS-1:0] ref_rdata_i,
  output cost_wr_t                      cwr_o,
  output logic                          busy_o,
  output logic [COST_W-1:0]             rowmin_o
);

  // stage 1: aligned with memory read data
  issue_t             s1_q;
  logic [COST_W-1:0]  up_eff;
  logic [COST_W-1:0]  last_up_q;
  logic               first_q;
  // stage 2
  logic               s2_v_q, s2_first_q;
  logic [CNT_W-1:0]   s2_k_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic [COST_W-1:0]  up_q, diag_q;
  // stage 3
  logic               s3_v_q, s3_first_q;
  logic [CNT_W-1:0]   s3_k_q;
  logic signed [2*DIFF_W-1:0] prod;
  logic [SQ_W-1:0]    sq_q;
  logic [COST_W-1:0]  m_q;
  // stage 4: left-neighbor recurrence
  logic               s4_v_q, s4_first_q;
  logic [CNT_W-1:0]   s4_k_q;
  logic [COST_W-1:0]  pu_q;
  logic [SQ_W-1:0]    sq4_q;
  logic [COST_W-1:0]  left, alt, cell_d, cell_q;
  // stage 5: row minimum
  logic               s5_v_q;
  logic [COST_W-1:0]  rowmin_q;
  logic signed [DIFF_W-1:0] diff_d;

  assign up_eff = eff_cost(s1_q.k, cost_rdata_i, row_i);
  assign diff_d = $signed({q_i[SAMPLE_BITS-1], q_i})
                - $signed({ref_rdata_i[SAMPLE_BITS-1], ref_rdata_i});
  assign prod   = diff_q * diff_q;

  assign left   = s4_first_q ? COST_INF : cell_q;
  assign alt    = sat_add(COST_W'(sq4_q), left);
  assign cell_d = min_cost(pu_q, alt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q     <= '0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      s4_v_q   <= 1'b0;
      s5_v_q   <= 1'b0;
      first_q  <= 1'b0;
      rowmin_q <= COST_INF;
    end else begin
      s1_q   <= iss_i;
      s2_v_q <= s1_q.vld && !s1_q.pre;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      if (s1_q.vld) begin
        first_q <= s1_q.pre;
      end
      if (s1_q.vld && s1_q.pre) begin
        rowmin_q <= COST_INF;
      end else if (s5_v_q) begin
        rowmin_q <= min_cost(rowmin_q, cell_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_q.vld) begin
      last_up_q <= up_eff;
    end
    s2_first_q <= first_q;
    s2_k_q     <= s1_q.k;
    diff_q     <= diff_d;
    up_q       <= up_eff;
    diag_q     <= last_up_q;

    s3_first_q <= s2_first_q;
    s3_k_q     <= s2_k_q;
    sq_q       <= prod[SQ_W-1:0];
    m_q        <= min_cost(up_q, diag_q);

    s4_first_q <= s3_first_q;
    s4_k_q     <= s3_k_q;
    pu_q       <= sat_add(COST_W'(sq_q), m_q);
    sq4_q      <= sq_q;

    if (s4_v_q) begin
      cell_q <= cell_d;
    end
  end

  assign cwr_o.we   = s4_v_q;
  assign cwr_o.addr = s4_k_q;
  assign cwr_o.data = cell_d;
  assign busy_o     = s1_q.vld || s2_v_q || s3_v_q || s4_v_q || s5_v_q;
  assign rowmin_o   = rowmin_q;

endmodule

FILE: sv/banded_dtw_distance.sv
// Banded DTW distance with early abandon: sequencer, config and result register.
// A reference load is taken in the idle state. A query sample sweeps its band row through the
// single cost memory port at one cell per cycle: after the accept and the setup states it
// reads the columns in band plus one leading diagonal read (an empty row skips the reads),
// then the pipeline drains and the row closes. A sample after abandon is taken without a
// sweep; the last sample adds the corner read and waits while the output register is
// stalled. Cost rows need no clearing: live entries of the previous row are tracked by a
// column range, everything outside reads as infinity (all ones). A result waits in an
// output register while the next item is already taken.
module banded_dtw_distance import bdtw_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [COST_W-1:0]             distance_o,
  output logic                          completed_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [COST_W-1:0]             cfg_data_i
);

  state_e                        state_q, state_d;
  logic                          active_q, active_d;
  logic                          abandoned_q, abandoned_d;
  logic [COST_W-1:0]             kept_q, kept_d;
  logic [ROW_W-1:0]              row_q, row_d;
  logic [CNT_W-1:0]              refcnt_q, refcnt_d;
  logic [BAND_W-1:0]             band_q, band_d;
  logic [COST_W-1:0]             thr_q, thr_d;
  logic signed [SAMPLE_BITS-1:0] smp_q, smp_d;
  logic                          last_q, last_d;
  logic [ROW_W-1:0]              begin_q, begin_d;
  logic [CNT_W-1:0]              end_q, end_d;
  logic                          empty_q, empty_d;
  logic [CNT_W-1:0]              k_q, k_d;
  row_t                          prev_q, prev_d;
  logic                          out_vld_q, out_vld_d;
  logic [COST_W-1:0]             out_dist_q, out_dist_d;
  logic                          out_comp_q, out_comp_d;

  logic                          in_acc;
  logic                          ref_we, ref_re;
  logic [REF_AW-1:0]             ref_raddr;
  logic signed [SAMPLE_BITS-1:0] ref_rdata;
  logic [CNT_W-1:0]              k_prev;
  logic                          crd_re;
  logic [CNT_W-1:0]              crd_addr;
  logic [COST_W-1:0]             crd_data;
  issue_t                        iss;
  cost_wr_t                      cwr;
  logic                          pipe_busy;
  logic [COST_W-1:0]             pipe_rowmin;
  logic [COST_W-1:0]             rm;
  logic [ROW_W:0]                end_sum;
  logic [ROW_W-1:0]              band_ext;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign k_prev      = k_q - CNT_W'(1);
  assign ref_raddr   = k_prev[REF_AW-1:0];
  assign ref_re      = iss.vld;
  assign band_ext    = ROW_W'(band_q);
  assign end_sum     = {1'b0, row_q} + (ROW_W + 1)'(band_q);
  assign rm          = empty_q ? COST_INF : pipe_rowmin;

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    abandoned_d = abandoned_q;
    kept_d      = kept_q;
    row_d       = row_q;
    refcnt_d    = refcnt_q;
    band_d      = band_q;
    thr_d       = thr_q;
    smp_d       = smp_q;
    last_d      = last_q;
    begin_d     = begin_q;
    end_d       = end_q;
    empty_d     = empty_q;
    k_d         = k_q;
    prev_d      = prev_q;
    out_vld_d   = out_vld_q;
    out_dist_d  = out_dist_q;
    out_comp_d  = out_comp_q;
    ref_we      = 1'b0;
    iss         = '0;
    crd_re      = 1'b0;
    crd_addr    = k_q;

    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_BAND:   band_d = cfg_data_i[BAND_W-1:0];
        REG_THRESH: thr_d  = cfg_data_i;
        default:    ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (kind_e'(kind_i) == KIND_REF) begin
            if (!active_q && refcnt_q < CNT_W'(MAX_LEN)) begin
              ref_we   = 1'b1;
              refcnt_d = refcnt_q + CNT_W'(1);
            end
          end else begin
            smp_d  = sample_i;
            last_d = last_i;
            if (!active_q) begin
              active_d    = 1'b1;
              abandoned_d = 1'b0;
              kept_d      = COST_INF;
              row_d       = '0;
              prev_d      = '{prev_init: 1'b1, prev_empty: 1'b0, lo: '0, hi: '0};
            end
            if (!(active_q && abandoned_q)) begin
              state_d = ST_SETUP;
            end else if (last_i) begin
              state_d = ST_FIN_RD;
            end
          end
        end
      end
      ST_SETUP: begin
        begin_d = (row_q > band_ext) ? (row_q - band_ext) : '0;
        end_d   = (end_sum > (ROW_W + 1)'(refcnt_q)) ? refcnt_q : end_sum[CNT_W-1:0];
        state_d = ST_SPAN;
      end
      ST_SPAN: begin
        if (begin_q >= ROW_W'(end_q)) begin
          empty_d = 1'b1;
          state_d = ST_ROW_DONE;
        end else begin
          empty_d = 1'b0;
          k_d     = begin_q[CNT_W-1:0];
          state_d = ST_STREAM;
        end
      end
      ST_STREAM: begin
        // addresses begin..end: the first read only fetches the diagonal
        iss.vld  = 1'b1;
        iss.pre  = (k_q == begin_q[CNT_W-1:0]);
        iss.k    = k_q;
        crd_re   = 1'b1;
        crd_addr = k_q;
        if (k_q == end_q) begin
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_d = ST_ROW_DONE;
        end
      end
      ST_ROW_DONE: begin
        if (rm != COST_INF) begin
          kept_d = rm;
        end
        if (rm > thr_q) begin
          abandoned_d = 1'b1;
        end
        if (row_q != ROW_MAX) begin
          row_d = row_q + ROW_W'(1);
        end
        prev_d.prev_init  = 1'b0;
        prev_d.prev_empty = empty_q;
        prev_d.lo         = begin_q[CNT_W-1:0] + CNT_W'(1);
        prev_d.hi         = end_q;
        state_d = last_q ? ST_FIN_RD : ST_IDLE;
      end
      ST_FIN_RD: begin
        crd_re   = !abandoned_q;
        crd_addr = refcnt_q;
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d  = 1'b1;
          out_dist_d = abandoned_q ? kept_q : eff_cost(refcnt_q, crd_data, prev_q);
          out_comp_d = !abandoned_q;
          active_d   = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 1'b0;
      abandoned_q <= 1'b0;
      kept_q      <= COST_INF;
      row_q       <= '0;
      refcnt_q    <= '0;
      band_q      <= BAND_W'(MAX_LEN);
      thr_q       <= COST_INF;
      empty_q     <= 1'b0;
      k_q         <= '0;
      prev_q      <= '{prev_init: 1'b1, prev_empty: 1'b0, lo: '0, hi: '0};
      out_vld_q   <= 1'b0;
      last_q      <= 1'b0;
      begin_q     <= '0;
      end_q       <= '0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      abandoned_q <= abandoned_d;
      kept_q      <= kept_d;
      row_q       <= row_d;
      refcnt_q    <= refcnt_d;
      band_q      <= band_d;
      thr_q       <= thr_d;
      empty_q     <= empty_d;
      k_q         <= k_d;
      prev_q      <= prev_d;
      out_vld_q   <= out_vld_d;
      last_q      <= last_d;
      begin_q     <= begin_d;
      end_q       <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q      <= smp_d;
    out_dist_q <= out_dist_d;
    out_comp_q <= out_comp_d;
  end

  bdtw_ref_store u_ref_store (
    .clk_i   (clk_i),
    .we_i    (ref_we),
    .waddr_i (refcnt_q[REF_AW-1:0]),
    .wdata_i (sample_i),
    .re_i    (ref_re),
    .raddr_i (ref_raddr),
    .rdata_o (ref_rdata)
  );

  bdtw_cost_store u_cost_store (
    .clk_i   (clk_i),
    .wr_i    (cwr),
    .re_i    (crd_re),
    .raddr_i (crd_addr),
    .rdata_o (crd_data)
  );

  bdtw_cell_pipe u_cell_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .iss_i        (iss),
    .row_i        (prev_q),
    .q_i          (smp_q),
    .cost_rdata_i (crd_data),
    .ref_rdata_i  (ref_rdata),
    .cwr_o        (cwr),
    .busy_o       (pipe_busy),
    .rowmin_o     (pipe_rowmin)
  );

  assign out_valid_o = out_vld_q;
  assign distance_o  = out_dist_q;
  assign completed_o = out_comp_q;

  // a result only appears out of the final state
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_FIN))
    else $error("result register loaded outside final state");

  // the cost memory is quiet whenever new items can enter
  a_no_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !cwr.we)
    else $error("cost write while idle");

  // sweep addresses stay within the band span
  a_sweep_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STREAM) |-> (k_q <= end_q && ROW_W'(k_q) >= begin_q))
    else $error("sweep address outside band");

  // row bookkeeping only after the pipeline has drained
  a_row_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROW_DONE) |-> !pipe_busy)
    else $error("row closed with cells in flight");

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the banded DTW distance block: directed steps, random queries.
module testbench;
  import bdtw_pkg::*;

  localparam int SETTLE_CYCLES = 1200;  // one full band row plus setup and corner read
  localparam int HOLD_CYCLES   = 3000;
  localparam logic [COST_W-1:0] COST_MAX_FINITE = COST_INF - 1;

  typedef struct packed {
    logic                   is_cfg;
    logic [BAND_W-1:0]      band;
    logic [COST_W-1:0]      thr;
    kind_e                  kind;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
    logic                   typed;
    logic [COST_W-1:0]      want_dist;
    logic                   want_done;
  } step_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              done;
  } dtw_result_t;

  typedef enum int {
    SINK_FREE,
    SINK_SPARSE,
    SINK_HEAVY,
    SINK_PERIODIC
  } sink_mode_e;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic                          kind_i;
  logic signed [SAMPLE_BITS-1:0] sample_i;
  logic                          last_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [COST_W-1:0]             distance_o;
  logic                          completed_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic                          cfg_index_i;
  logic [COST_W-1:0]             cfg_data_i;

  banded_dtw_distance dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .sample_i    (sample_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .distance_o  (distance_o),
    .completed_o (completed_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // alignment state mirrored from the block
  logic signed [SAMPLE_BITS-1:0] ref_mem [MAX_LEN];
  logic [COST_W-1:0]             prev_row [MAX_LEN+1];
  logic [COST_W-1:0]             new_row [MAX_LEN+1];
  int unsigned                   ref_cnt = 0;
  int unsigned                   row_idx = 0;
  bit                            gave_up = 1'b0;
  bit                            in_query = 1'b0;
  logic [COST_W-1:0]             kept_min = COST_INF;
  logic [BAND_W-1:0]             band_m = 11'd1024;
  logic [COST_W-1:0]             thr_m = COST_INF;

  dtw_result_t due[$];
  dtw_result_t seen_head;
  step_t       plan[$];
  int          mismatches = 0;
  int          burst_left = 0;
  bit          calm = 1'b0;
  bit          hold_wanted = 1'b0;
  bit          hold_served = 1'b0;

  function automatic logic [COST_W-1:0] cost_add(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    if (a == COST_INF || b == COST_INF) begin
      return COST_INF;
    end
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_INF : s[COST_W-1:0];
  endfunction

  task automatic sweep_row(input logic signed [SAMPLE_BITS-1:0] q);
    int unsigned       lo;
    int unsigned       hi;
    int unsigned       j;
    int unsigned       k;
    longint            d;
    logic [COST_W-1:0] sq;
    logic [COST_W-1:0] best;
    logic [COST_W-1:0] cell_cost;
    logic [COST_W-1:0] row_min;
    lo = (row_idx > band_m) ? row_idx - band_m : 0;
    hi = row_idx + band_m;
    if (hi > ref_cnt) begin
      hi = ref_cnt;
    end
    row_min = COST_INF;
    for (k = 0; k <= MAX_LEN; k++) new_row[k] = COST_INF;
    for (j = lo; j < hi; j++) begin
      d = longint'(q) - longint'(ref_mem[j]);
      if (d < 0) begin
        d = -d;
      end
      sq = COST_W'(d * d);
      best = prev_row[j+1];
      if (new_row[j] < best) best = new_row[j];
      if (prev_row[j] < best) best = prev_row[j];
      cell_cost = cost_add(sq, best);
      new_row[j+1] = cell_cost;
      if (cell_cost < row_min) row_min = cell_cost;
    end
    for (k = 0; k <= MAX_LEN; k++) prev_row[k] = new_row[k];
    // an all-infinity row leaves the kept minimum alone
    if (row_min != COST_INF) kept_min = row_min;
    if (row_min > thr_m) gave_up = 1'b1;
    if (row_idx < 65535) row_idx++;
  endtask

  task automatic advance_alignment(input kind_e kind, input logic [SAMPLE_BITS-1:0] raw,
                                   input logic last, output bit got,
                                   output dtw_result_t res);
    int k;
    got = 1'b0;
    res = '0;
    if (kind == KIND_REF) begin
      if (!in_query && ref_cnt < MAX_LEN) begin
        ref_mem[ref_cnt] = raw;
        ref_cnt++;
      end
      return;
    end
    if (!in_query) begin
      prev_row[0] = '0;
      for (k = 1; k <= MAX_LEN; k++) prev_row[k] = COST_INF;
      row_idx = 0;
      gave_up = 1'b0;
      kept_min = COST_INF;
      in_query = 1'b1;
    end
    if (!gave_up) sweep_row(raw);
    if (!last) return;
    got = 1'b1;
    res.cost = gave_up ? kept_min : prev_row[ref_cnt];
    res.done = !gave_up;
    in_query = 1'b0;
  endtask

  task automatic note_mismatch(input string what, input logic [COST_W-1:0] got,
                               input logic [COST_W-1:0] want);
    $display("mismatch on %s: got %h, want %h", what, got, want);
    mismatches++;
  endtask

  // result side
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due.size() == 0) begin
        note_mismatch("result with nothing due", distance_o, '0);
      end else begin
        seen_head = due.pop_front();
        if (distance_o !== seen_head.cost) note_mismatch("distance", distance_o, seen_head.cost);
        if (completed_o !== seen_head.done) begin
          note_mismatch("completed", COST_W'(completed_o), COST_W'(seen_head.done));
        end
      end
    end
  end

  initial begin : receiver
    sink_mode_e mode;
    int         span;
    int         tick;
    int         held;
    out_stall_i = 1'b0;
    mode = SINK_FREE;
    span = 0;
    tick = 0;
    forever begin
      @(negedge clk_i);
      if (hold_wanted && !hold_served) begin
        hold_served = 1'b1;
        out_stall_i <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk_i);
      end
      if (span == 0) begin
        mode = sink_mode_e'($urandom_range(0, 3));
        span = $urandom_range(20, 300);
      end
      span--;
      tick++;
      case (mode)
        SINK_FREE:   out_stall_i <= 1'b0;
        SINK_SPARSE: out_stall_i <= ($urandom_range(0, 99) < 30);
        SINK_HEAVY:  out_stall_i <= ($urandom_range(0, 99) < 80);
        default:     out_stall_i <= (tick % 7 < 3);
      endcase
    end
  end

  task automatic send_item(input step_t st);
    bit          got;
    dtw_result_t res;
    in_valid_i <= 1'b1;
    kind_i     <= st.kind;
    sample_i   <= st.sample;
    last_i     <= st.last;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    advance_alignment(st.kind, st.sample, st.last, got, res);
    if (got) begin
      if (st.typed) begin
        res.cost = st.want_dist;
        res.done = st.want_done;
      end
      due.push_back(res);
    end
    @(negedge clk_i);
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 24);
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic offer(input kind_e kind, input logic [SAMPLE_BITS-1:0] s, input logic last);
    step_t st;
    st = '0;
    st.kind = kind;
    st.sample = s;
    st.last = last;
    send_item(st);
    pace();
  endtask

  // wait out every due result, then the longest row still in flight
  task automatic settle();
    in_valid_i <= 1'b0;
    while (due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [BAND_W-1:0] band, input logic [COST_W-1:0] thr);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_BAND;
    cfg_data_i  <= COST_W'(band);
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    band_m = band;
    @(negedge clk_i);
    cfg_index_i <= REG_THRESH;
    cfg_data_i  <= thr;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    thr_m = thr;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2, 3, 4: return 16'($urandom);
      default: return 16'($urandom_range(0, 127) - 64);
    endcase
  endfunction

  function automatic void ld(input logic [SAMPLE_BITS-1:0] s, input logic last);
    step_t st;
    st = '0;
    st.kind = KIND_REF;
    st.sample = s;
    st.last = last;
    plan.push_back(st);
  endfunction

  function automatic void qs(input logic [SAMPLE_BITS-1:0] s, input logic last);
    step_t st;
    st = '0;
    st.kind = KIND_QUERY;
    st.sample = s;
    st.last = last;
    plan.push_back(st);
  endfunction

  function automatic void qx(input logic [SAMPLE_BITS-1:0] s, input logic [COST_W-1:0] want,
                             input logic done);
    step_t st;
    st = '0;
    st.kind = KIND_QUERY;
    st.sample = s;
    st.last = 1'b1;
    st.typed = 1'b1;
    st.want_dist = want;
    st.want_done = done;
    plan.push_back(st);
  endfunction

  function automatic void cf(input logic [BAND_W-1:0] band, input logic [COST_W-1:0] thr);
    step_t st;
    st = '0;
    st.is_cfg = 1'b1;
    st.band = band;
    st.thr = thr;
    plan.push_back(st);
  endfunction

  initial begin : stimulus
    int                ph;
    int                n;
    int                len;
    int                k;
    int                quota;
    logic [BAND_W-1:0] w;
    logic [COST_W-1:0] thr;
    in_valid_i  = 1'b0;
    kind_i      = KIND_REF;
    sample_i    = '0;
    last_i      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_BAND;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    qx(16'd0, COST_INF, 1'b1);          // empty reference: corner stays infinite
    ld(16'h8000, 1'b1);                 // last is ignored on loads
    ld(16'h7FFF, 1'b0);
    ld(16'h0000, 1'b0);
    ld(16'hFFFF, 1'b0);
    qs(16'h7FFF, 1'b0);
    ld(16'd100, 1'b1);                  // dropped, query is open
    qs(16'h8000, 1'b0);
    qs(16'h0000, 1'b1);
    qs(16'h8000, 1'b1);
    cf(11'd0, COST_INF);                // zero band: every row empty
    qx(16'd5, COST_INF, 1'b1);
    cf(11'd0, '0);                      // empty row now abandons with no finite minimum
    qx(16'hFFFB, COST_INF, 1'b0);
    qs(16'd1, 1'b0);
    qs(16'd2, 1'b0);
    qx(16'd3, COST_INF, 1'b0);
    cf(11'd1024, '0);
    qs(16'h8000, 1'b0);
    qs(16'h7FFF, 1'b1);
    cf(11'd1, COST_MAX_FINITE);         // band runs off the store, reports the kept minimum
    qs(16'd10, 1'b0);
    qs(16'd20, 1'b0);
    qs(16'd30, 1'b0);
    qs(16'd40, 1'b0);
    qs(16'd50, 1'b0);
    qs(16'd60, 1'b1);

    foreach (plan[r]) begin
      if (plan[r].is_cfg) begin
        settle();
        program_regs(plan[r].band, plan[r].thr);
      end else begin
        send_item(plan[r]);
        pace();
      end
    end

    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin w = 11'd1024; thr = COST_INF; quota = 60; end
        1: begin w = 11'd2; thr = COST_W'($urandom()); quota = 90; end
        2: begin w = 11'd0; thr = COST_INF; quota = 40; end
        3: begin
          w     = BAND_W'($urandom_range(1, 16));
          thr   = COST_W'({$urandom, $urandom});
          quota = 90;
        end
        4: begin w = 11'd5; thr = COST_MAX_FINITE; quota = 90; end
        5: begin w = 11'd1; thr = COST_INF; quota = 60; end
        default: begin w = 11'd1024; thr = COST_W'($urandom_range(0, 5000)); quota = 60; end
      endcase
      settle();
      program_regs(w, thr);
      calm = (ph == 4);
      // long receiver hold while short queries keep coming
      if (ph == 5) hold_wanted = 1'b1;
      n = 0;
      while (n < quota) begin
        if ($urandom_range(0, 99) < 12) begin
          offer(KIND_REF, pick_sample(), 1'($urandom_range(0, 1)));
          n++;
        end else begin
          if (ph == 5) len = $urandom_range(1, 2);
          else if ($urandom_range(0, 9) == 0) len = $urandom_range(9, 30);
          else len = $urandom_range(1, 6);
          for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 19) == 0) begin
              offer(KIND_REF, pick_sample(), 1'($urandom_range(0, 1)));
            end
            offer(KIND_QUERY, pick_sample(), k == len - 1);
            n++;
          end
        end
      end
      // leave a query open across the next register write
      if (ph == 3) begin
        offer(KIND_QUERY, pick_sample(), 1'b0);
        offer(KIND_QUERY, pick_sample(), 1'b0);
      end
    end

    // grow the store a little more, then sweep narrow and full bands over it
    settle();
    program_regs(11'd3, COST_INF);
    calm = 1'b0;
    for (k = 0; k < 20; k++) offer(KIND_REF, pick_sample(), 1'($urandom_range(0, 1)));
    for (k = 0; k < 6; k++) offer(KIND_QUERY, pick_sample(), k == 5);
    settle();
    program_regs(11'd1024, COST_INF);
    offer(KIND_QUERY, pick_sample(), 1'b0);
    offer(KIND_QUERY, pick_sample(), 1'b1);
    settle();

    if (mismatches == 0) begin
      $display("[banded_dtw_distance] OK");
    end else begin
      $display("[banded_dtw_distance] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("[banded_dtw_distance] ERROR");
    $finish;
  end

endmodule

FILE: sim.f
sv/bdtw_pkg.sv
sv/bdtw_ref_store.sv
sv/bdtw_cost_store.sv
sv/bdtw_cell_pipe.sv
sv/banded_dtw_distance.sv
bench/testbench.sv
